### design/adsr_pkg.sv
// ----------------------------------------------------------------------------
// ADSR envelope package
// Phase codes, register indexes, register reset values and the register
// record shared by the envelope modules.
// ----------------------------------------------------------------------------
package adsr_pkg;

   localparam int CSR_INDEX_BITS = 3;
   localparam int CSR_DATA_BITS  = 24;
   localparam int SUSTAIN_BITS   = 23;
   localparam int RATE_BITS      = 24;
   localparam int COEF_BITS      = 16;
   localparam int PHASE_BITS     = 3;

   typedef enum logic [PHASE_BITS-1:0] {
      PH_OFF     = 3'd0,
      PH_ATTACK  = 3'd1,
      PH_DECAY   = 3'd2,
      PH_SUSTAIN = 3'd3,
      PH_RELEASE = 3'd4
   } phase_type;

   typedef enum logic [CSR_INDEX_BITS-1:0] {
      CSR_EXP_MODE      = 3'd0,
      CSR_SUSTAIN_LEVEL = 3'd1,
      CSR_ATTACK_RATE   = 3'd2,
      CSR_DECAY_RATE    = 3'd3,
      CSR_RELEASE_RATE  = 3'd4,
      CSR_ATTACK_COEF   = 3'd5,
      CSR_DECAY_COEF    = 3'd6,
      CSR_RELEASE_COEF  = 3'd7
   } csr_index_type;

   typedef struct packed {
      logic                    exp_mode;
      logic [SUSTAIN_BITS-1:0] sustain_level;
      logic [RATE_BITS-1:0]    attack_rate;
      logic [RATE_BITS-1:0]    decay_rate;
      logic [RATE_BITS-1:0]    release_rate;
      logic [COEF_BITS-1:0]    attack_coef;
      logic [COEF_BITS-1:0]    decay_coef;
      logic [COEF_BITS-1:0]    release_coef;
   } adsr_cfg_type;

   localparam adsr_cfg_type CFG_RESET = '{
      exp_mode:      1'b0,
      sustain_level: 23'd0,
      attack_rate:   24'd83886,
      decay_rate:    24'd83886,
      release_rate:  24'd47934,
      attack_coef:   16'd63762,
      decay_coef:    16'd62627,
      release_coef:  16'd26400
   };

endpackage

### design/adsr_csr.sv
// ----------------------------------------------------------------------------
// ADSR register file
// Holds the configuration registers and the per-tick quantities that depend
// on them alone: clamped sustain level and the linear attack and decay steps.
// ----------------------------------------------------------------------------
module adsr_csr
   import adsr_pkg::*;
#(
   parameter int LEVEL_BITS = 22
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata,
   output adsr_cfg_type              cfg,
   output logic [LEVEL_BITS:0]       sus,
   output logic [LEVEL_BITS:0]       atk_step,
   output logic [LEVEL_BITS:0]       dec_step
);

   localparam int W  = LEVEL_BITS + 1;
   localparam int SW = (W > SUSTAIN_BITS) ? W : SUSTAIN_BITS;
   localparam int AW = LEVEL_BITS + RATE_BITS;
   localparam int PW = W + RATE_BITS;
   localparam logic [W-1:0]  FULL_SCALE = W'(1) << LEVEL_BITS;
   localparam logic [SW-1:0] FS_WIDE    = SW'(1) << LEVEL_BITS;

   adsr_cfg_type   cfg_ff, cfg_in;
   logic [W-1:0]   sus_ff, sus_in;
   logic [W-1:0]   atk_step_ff, atk_step_in;
   logic [W-1:0]   dec_step_ff, dec_step_in;
   logic [SW-1:0]  sus_wide;
   logic [AW-1:0]  atk_wide;
   logic [W-1:0]   atk_raw;
   logic [W-1:0]   dec_span;
   logic [PW-1:0]  dec_prod;
   logic [W-1:0]   dec_raw;

   always_comb begin
      cfg_in = cfg_ff;
      if (reset) begin
         cfg_in = CFG_RESET;
      end else if (csr_wen) begin
         unique case (csr_index)
            CSR_EXP_MODE:      cfg_in.exp_mode      = csr_wdata[0];
            CSR_SUSTAIN_LEVEL: cfg_in.sustain_level = csr_wdata[SUSTAIN_BITS-1:0];
            CSR_ATTACK_RATE:   cfg_in.attack_rate   = csr_wdata[RATE_BITS-1:0];
            CSR_DECAY_RATE:    cfg_in.decay_rate    = csr_wdata[RATE_BITS-1:0];
            CSR_RELEASE_RATE:  cfg_in.release_rate  = csr_wdata[RATE_BITS-1:0];
            CSR_ATTACK_COEF:   cfg_in.attack_coef   = csr_wdata[COEF_BITS-1:0];
            CSR_DECAY_COEF:    cfg_in.decay_coef    = csr_wdata[COEF_BITS-1:0];
            CSR_RELEASE_COEF:  cfg_in.release_coef  = csr_wdata[COEF_BITS-1:0];
            default: ;
         endcase
      end
   end

   // Derived values follow the next register contents, so they are registered
   // on the same edge as the registers they come from.
   always_comb begin
      sus_wide = SW'(cfg_in.sustain_level);
      sus_in   = (sus_wide > FS_WIDE) ? FULL_SCALE : W'(sus_wide);

      // Full scale times a Q24 rate is a plain shift.
      atk_wide    = (AW'(cfg_in.attack_rate) << LEVEL_BITS) >> RATE_BITS;
      atk_raw     = W'(atk_wide);
      atk_step_in = (atk_raw == '0) ? W'(1) : atk_raw;

      dec_span    = FULL_SCALE - sus_in;
      dec_prod    = PW'(dec_span) * PW'(cfg_in.decay_rate);
      dec_raw     = W'(dec_prod >> RATE_BITS);
      dec_step_in = (dec_raw == '0) ? W'(1) : dec_raw;
   end

   always_ff @(posedge clock) begin
      cfg_ff      <= cfg_in;
      sus_ff      <= sus_in;
      atk_step_ff <= atk_step_in;
      dec_step_ff <= dec_step_in;
   end

   assign cfg      = cfg_ff;
   assign sus      = sus_ff;
   assign atk_step = atk_step_ff;
   assign dec_step = dec_step_ff;

endmodule

### design/adsr_step.sv
// ----------------------------------------------------------------------------
// ADSR tick update
// Combinational next phase, next level and release step for one tick, plus
// the converter code of the new level.
// ----------------------------------------------------------------------------
module adsr_step
   import adsr_pkg::*;
#(
   parameter int LEVEL_BITS = 22,
   parameter int DAC_BITS   = 12
) (
   input  adsr_cfg_type        cfg,
   input  logic [LEVEL_BITS:0] sus,
   input  logic [LEVEL_BITS:0] atk_step,
   input  logic [LEVEL_BITS:0] dec_step,
   input  logic                gate,
   input  phase_type           phase_cur,
   input  logic [LEVEL_BITS:0] level_cur,
   input  logic [LEVEL_BITS:0] rel_step_cur,
   output phase_type           phase_nxt,
   output logic [LEVEL_BITS:0] level_nxt,
   output logic [LEVEL_BITS:0] rel_step_nxt,
   output logic [DAC_BITS-1:0] dac_code
);

   localparam int W  = LEVEL_BITS + 1;
   localparam int AW = W + 1;
   localparam int EW = AW + COEF_BITS;
   localparam int CW = W + COEF_BITS;
   localparam int RW = W + RATE_BITS;
   localparam int DW = W + DAC_BITS;
   localparam logic [W-1:0]  FULL_SCALE = W'(1) << LEVEL_BITS;
   localparam logic [AW-1:0] FS_ATK     = AW'(1) << LEVEL_BITS;
   localparam logic [AW-1:0] TARGET     = (AW'(1) << LEVEL_BITS) + (AW'(1) << (LEVEL_BITS - 1));
   localparam logic [W-1:0]  FLOOR      = W'((64'd1 << LEVEL_BITS) / 660);
   localparam logic [DW-1:0] DAC_MAX    = DW'((64'd1 << DAC_BITS) - 64'd1);

   logic [EW-1:0] atk_prod;
   logic [AW-1:0] atk_exp;
   logic [AW-1:0] atk_lin;
   logic [AW-1:0] atk_new;
   logic [W-1:0]  dec_excess;
   logic [CW-1:0] dec_prod;
   logic [W-1:0]  dec_exp;
   logic [W-1:0]  dec_lin;
   logic [W-1:0]  dec_new;
   logic [CW-1:0] rel_prod;
   logic [W-1:0]  rel_exp;
   logic [RW-1:0] rs_prod;
   logic [W-1:0]  rs_raw;
   logic [W-1:0]  rs_new;
   logic [DW-1:0] code_wide;

   always_comb begin
      // Exponential attack keeps a fraction of the distance to 1.5x full scale.
      atk_prod = EW'(TARGET - AW'(level_cur)) * EW'(cfg.attack_coef);
      atk_exp  = TARGET - AW'(atk_prod >> COEF_BITS);
      atk_lin  = AW'(level_cur) + AW'(atk_step);
      atk_new  = cfg.exp_mode ? atk_exp : atk_lin;

      dec_excess = level_cur - sus;
      dec_prod   = CW'(dec_excess) * CW'(cfg.decay_coef);
      dec_exp    = sus + W'(dec_prod >> COEF_BITS);
      dec_lin    = (level_cur > dec_step) ? level_cur - dec_step : '0;
      dec_new    = cfg.exp_mode ? dec_exp : dec_lin;

      rel_prod = CW'(level_cur) * CW'(cfg.release_coef);
      rel_exp  = W'(rel_prod >> COEF_BITS);

      // Step used if this tick starts the release.
      rs_prod = RW'(level_cur) * RW'(cfg.release_rate);
      rs_raw  = W'(rs_prod >> RATE_BITS);
      rs_new  = (rs_raw == '0) ? W'(1) : rs_raw;
   end

   always_comb begin
      phase_nxt    = phase_cur;
      level_nxt    = level_cur;
      rel_step_nxt = rel_step_cur;
      case (phase_cur)
         PH_ATTACK: begin
            if (!gate) begin
               rel_step_nxt = rs_new;
               phase_nxt    = PH_RELEASE;
            end else if (atk_new >= FS_ATK) begin
               level_nxt = FULL_SCALE;
               phase_nxt = PH_DECAY;
            end else begin
               level_nxt = W'(atk_new);
            end
         end
         PH_DECAY: begin
            if (!gate) begin
               rel_step_nxt = rs_new;
               phase_nxt    = PH_RELEASE;
            end else if (level_cur <= sus || dec_new <= sus) begin
               level_nxt = sus;
               phase_nxt = PH_SUSTAIN;
            end else begin
               level_nxt = dec_new;
            end
         end
         PH_SUSTAIN: begin
            if (!gate) begin
               rel_step_nxt = rs_new;
               phase_nxt    = PH_RELEASE;
            end else begin
               level_nxt = sus;
            end
         end
         PH_RELEASE: begin
            if (cfg.exp_mode) begin
               if (rel_exp <= FLOOR) begin
                  level_nxt = '0;
                  phase_nxt = PH_OFF;
               end else begin
                  level_nxt = rel_exp;
               end
            end else if (level_cur <= rel_step_cur) begin
               level_nxt = '0;
               phase_nxt = PH_OFF;
            end else begin
               level_nxt = level_cur - rel_step_cur;
            end
         end
         default: begin
            phase_nxt = PH_OFF;
            if (gate) begin
               level_nxt = '0;
               phase_nxt = PH_ATTACK;
            end
         end
      endcase
   end

   // level * (2^DAC_BITS - 1) as a shift and a subtract.
   always_comb begin
      code_wide = ((DW'(level_nxt) << DAC_BITS) - DW'(level_nxt)) >> LEVEL_BITS;
      dac_code  = (code_wide > DAC_MAX) ? DAC_MAX[DAC_BITS-1:0] : code_wide[DAC_BITS-1:0];
   end

endmodule

### design/adsr_envelope_generator_core.sv
// ----------------------------------------------------------------------------
// ADSR envelope generator core
// One gate sample per transaction in, one converter code and phase out.
// ----------------------------------------------------------------------------
// The core takes one tick transaction per clock cycle unless a stalled result
// side leaves both of its registers full, and returns each result through an
// input register and a result register; the envelope state (phase, level,
// release step) lives in one register loop closed through the tick update,
// whose longest path is one (LEVEL_BITS+1) by 24 bit multiplier followed by
// a compare and a select. A full result register does not stop a transaction
// entering an empty input register. Writes apply to ticks computed after them.
module adsr_envelope_generator_core
   import adsr_pkg::*;
#(
   parameter int LEVEL_BITS = 22,
   parameter int DAC_BITS   = 12
) (
   input  logic                      clock,
   input  logic                      reset,
   input  logic                      req_valid,
   output logic                      req_ready,
   input  logic                      req_gate,
   output logic                      rsp_valid,
   input  logic                      rsp_ready,
   output logic [DAC_BITS-1:0]       rsp_dac_code,
   output logic [PHASE_BITS-1:0]     rsp_phase,
   input  logic                      csr_wen,
   input  logic [CSR_INDEX_BITS-1:0] csr_index,
   input  logic [CSR_DATA_BITS-1:0]  csr_wdata
);

   localparam int W = LEVEL_BITS + 1;

   adsr_cfg_type        cfg;
   logic [W-1:0]        sus;
   logic [W-1:0]        atk_step;
   logic [W-1:0]        dec_step;

   logic                in_valid_ff, in_valid_in;
   logic                gate_ff, gate_in;
   logic                out_valid_ff, out_valid_in;
   logic [DAC_BITS-1:0] code_ff, code_in;
   phase_type           out_phase_ff, out_phase_in;
   phase_type           phase_ff, phase_in;
   logic [W-1:0]        level_ff, level_in;
   logic [W-1:0]        rel_step_ff, rel_step_in;

   phase_type           phase_nxt;
   logic [W-1:0]        level_nxt;
   logic [W-1:0]        rel_step_nxt;
   logic [DAC_BITS-1:0] dac_code;
   logic                advance;
   logic                take;

   adsr_csr #(.LEVEL_BITS(LEVEL_BITS)) u_csr (
      .clock     (clock),
      .reset     (reset),
      .csr_wen   (csr_wen),
      .csr_index (csr_index),
      .csr_wdata (csr_wdata),
      .cfg       (cfg),
      .sus       (sus),
      .atk_step  (atk_step),
      .dec_step  (dec_step)
   );

   adsr_step #(.LEVEL_BITS(LEVEL_BITS), .DAC_BITS(DAC_BITS)) u_step (
      .cfg          (cfg),
      .sus          (sus),
      .atk_step     (atk_step),
      .dec_step     (dec_step),
      .gate         (gate_ff),
      .phase_cur    (phase_ff),
      .level_cur    (level_ff),
      .rel_step_cur (rel_step_ff),
      .phase_nxt    (phase_nxt),
      .level_nxt    (level_nxt),
      .rel_step_nxt (rel_step_nxt),
      .dac_code     (dac_code)
   );

   // The held tick moves on whenever the result register is empty or is
   // being emptied in this cycle.
   assign advance   = in_valid_ff && (!out_valid_ff || rsp_ready);
   assign req_ready = !in_valid_ff || advance;
   assign take      = req_valid && req_ready;

   always_comb begin
      in_valid_in  = in_valid_ff;
      gate_in      = gate_ff;
      out_valid_in = out_valid_ff;
      code_in      = code_ff;
      out_phase_in = out_phase_ff;
      phase_in     = phase_ff;
      level_in     = level_ff;
      rel_step_in  = rel_step_ff;

      if (take) begin
         in_valid_in = 1'b1;
         gate_in     = req_gate;
      end else if (advance) begin
         in_valid_in = 1'b0;
      end

      if (advance) begin
         out_valid_in = 1'b1;
         code_in      = dac_code;
         out_phase_in = phase_nxt;
         phase_in     = phase_nxt;
         level_in     = level_nxt;
         rel_step_in  = rel_step_nxt;
      end else if (rsp_ready) begin
         out_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         in_valid_ff  <= 1'b0;
         out_valid_ff <= 1'b0;
         phase_ff     <= PH_OFF;
         level_ff     <= '0;
         rel_step_ff  <= '0;
      end else begin
         in_valid_ff  <= in_valid_in;
         out_valid_ff <= out_valid_in;
         phase_ff     <= phase_in;
         level_ff     <= level_in;
         rel_step_ff  <= rel_step_in;
      end
      gate_ff      <= gate_in;
      code_ff      <= code_in;
      out_phase_ff <= out_phase_in;
   end

   assign rsp_valid    = out_valid_ff;
   assign rsp_dac_code = code_ff;
   assign rsp_phase    = out_phase_ff;

endmodule

### design/adsr_checker.sv
// ----------------------------------------------------------------------------
// ADSR core checker
// Port-level properties of the envelope core, bound to the top level.
// ----------------------------------------------------------------------------
module adsr_checker
   import adsr_pkg::*;
#(
   parameter int DAC_BITS = 12
) (
   input logic                  clock,
   input logic                  reset,
   input logic                  req_ready,
   input logic                  rsp_valid,
   input logic                  rsp_ready,
   input logic [DAC_BITS-1:0]   rsp_dac_code,
   input logic [PHASE_BITS-1:0] rsp_phase
);

   // No result survives a reset.
   assert property (@(posedge clock) $past(reset) |-> !rsp_valid)
      else $error("result valid right after reset");

   // With the result register empty the core must take a new transaction.
   assert property (@(posedge clock) disable iff (reset) !rsp_valid |-> req_ready)
      else $error("input stalled while the result register is empty");

   // The envelope is always at zero while it is off.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_phase == PH_OFF) |-> (rsp_dac_code == '0))
      else $error("nonzero code reported in the off phase");

   // A stalled result holds.
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
         (rsp_valid && $stable(rsp_dac_code) && $stable(rsp_phase)))
      else $error("stalled result changed");

endmodule

bind adsr_envelope_generator_core adsr_checker #(.DAC_BITS(DAC_BITS)) u_adsr_checker (
   .clock        (clock),
   .reset        (reset),
   .req_ready    (req_ready),
   .rsp_valid    (rsp_valid),
   .rsp_ready    (rsp_ready),
   .rsp_dac_code (rsp_dac_code),
   .rsp_phase    (rsp_phase)
);

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// ADSR envelope generator core testbench
// Drives gate ticks through the request channel and checks every converter
// code and phase against the table or a tick-accurate envelope bench model.
// A short directed table covers the segment extremes and every transition.
// It is followed by random envelopes under several register settings, with
// random idling on both channels and one long stall of the result side.
// ----------------------------------------------------------------------------
module testbench;
   import adsr_pkg::*;

   localparam int          LEVEL_BITS  = 22;
   localparam int          DAC_BITS    = 12;
   localparam logic [63:0] FULL_SCALE  = 64'd1 << LEVEL_BITS;
   localparam logic [63:0] DAC_MAX     = (64'd1 << DAC_BITS) - 64'd1;
   localparam int          HOLD_CYCLES = 80;

   typedef struct packed {
      logic [DAC_BITS-1:0] dac_code;
      phase_type           phase;
   } tick_result_type;

   typedef struct packed {
      bit                         is_write;
      csr_index_type              index;
      logic [CSR_DATA_BITS-1:0]   data;
      logic                       gate;
      bit                         typed;
      tick_result_type            result;
   } stim_row_type;

   logic                      clock = 1'b0;
   logic                      reset = 1'b1;
   logic                      req_valid = 1'b0;
   logic                      req_ready;
   logic                      req_gate = 1'b0;
   logic                      rsp_valid;
   logic                      rsp_ready = 1'b0;
   logic [DAC_BITS-1:0]       rsp_dac_code;
   logic [PHASE_BITS-1:0]     rsp_phase;
   logic                      csr_wen = 1'b0;
   logic [CSR_INDEX_BITS-1:0] csr_index = '0;
   logic [CSR_DATA_BITS-1:0]  csr_wdata = '0;

   // Envelope model state and its copy of the registers.
   adsr_cfg_type env_cfg = CFG_RESET;
   phase_type    env_phase = PH_OFF;
   logic [63:0]  env_level = '0;
   logic [63:0]  rel_start = '0;
   logic [63:0]  rel_step = '0;

   tick_result_type pending_outputs[$];
   stim_row_type    stim_table[$];
   int              mismatch_count = 0;
   int              ticks_sent = 0;
   bit              hold_request = 1'b0;

   adsr_envelope_generator_core #(
      .LEVEL_BITS(LEVEL_BITS),
      .DAC_BITS  (DAC_BITS)
   ) dut (
      .clock       (clock),
      .reset       (reset),
      .req_valid   (req_valid),
      .req_ready   (req_ready),
      .req_gate    (req_gate),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_dac_code(rsp_dac_code),
      .rsp_phase   (rsp_phase),
      .csr_wen     (csr_wen),
      .csr_index   (csr_index),
      .csr_wdata   (csr_wdata)
   );

   always #5 clock = ~clock;

   initial begin
      #5000000;
      $display("testbench: FAIL");
      $finish;
   end

   function automatic logic [63:0] lin_step(input logic [63:0] span, input logic [23:0] rate);
      logic [63:0] s;
      s = (span * {40'd0, rate}) >> 24;
      return (s == 64'd0) ? 64'd1 : s;
   endfunction

   function automatic void start_release();
      rel_start = env_level;
      rel_step  = lin_step(rel_start, env_cfg.release_rate);
      env_phase = PH_RELEASE;
   endfunction

   function automatic tick_result_type advance_envelope(input logic g);
      logic [63:0]     sus;
      logic [63:0]     tgt;
      logic [63:0]     gap;
      logic [63:0]     st;
      logic [63:0]     code;
      tick_result_type r;
      sus = {41'd0, env_cfg.sustain_level};
      if (sus > FULL_SCALE) sus = FULL_SCALE;
      case (env_phase)
         PH_ATTACK: begin
            if (!g) begin
               start_release();
            end else begin
               if (env_cfg.exp_mode) begin
                  // Exponential attack aims past full scale so it actually gets there.
                  tgt = FULL_SCALE + (FULL_SCALE >> 1);
                  gap = tgt - env_level;
                  env_level = tgt - ((gap * {48'd0, env_cfg.attack_coef}) >> 16);
               end else begin
                  env_level = env_level + lin_step(FULL_SCALE, env_cfg.attack_rate);
               end
               if (env_level >= FULL_SCALE) begin
                  env_level = FULL_SCALE;
                  env_phase = PH_DECAY;
               end
            end
         end
         PH_DECAY: begin
            if (!g) begin
               start_release();
            end else if (env_level <= sus) begin
               env_level = sus;
               env_phase = PH_SUSTAIN;
            end else begin
               if (env_cfg.exp_mode) begin
                  env_level = sus + (((env_level - sus) * {48'd0, env_cfg.decay_coef}) >> 16);
               end else begin
                  st = lin_step(FULL_SCALE - sus, env_cfg.decay_rate);
                  env_level = (env_level > st) ? env_level - st : 64'd0;
               end
               if (env_level <= sus) begin
                  env_level = sus;
                  env_phase = PH_SUSTAIN;
               end
            end
         end
         PH_SUSTAIN: begin
            if (!g) start_release();
            else env_level = sus;
         end
         PH_RELEASE: begin
            // The gate has no say here; the segment always runs to the floor.
            if (env_cfg.exp_mode) begin
               env_level = (env_level * {48'd0, env_cfg.release_coef}) >> 16;
               if (env_level <= FULL_SCALE / 660) begin
                  env_level = 64'd0;
                  env_phase = PH_OFF;
               end
            end else if (env_level <= rel_step) begin
               env_level = 64'd0;
               env_phase = PH_OFF;
            end else begin
               env_level = env_level - rel_step;
            end
         end
         default: begin
            env_phase = PH_OFF;
            if (g) begin
               env_level = 64'd0;
               env_phase = PH_ATTACK;
            end
         end
      endcase
      code = (env_level * DAC_MAX) >> LEVEL_BITS;
      if (code > DAC_MAX) code = DAC_MAX;
      r.dac_code = code[DAC_BITS-1:0];
      r.phase    = env_phase;
      return r;
   endfunction

   function automatic void add_write(input csr_index_type idx, input logic [23:0] data);
      stim_row_type row;
      row = '0;
      row.is_write = 1'b1;
      row.index = idx;
      row.data = data;
      stim_table.push_back(row);
   endfunction

   function automatic void add_tick(input logic g, input bit typed,
                                    input logic [DAC_BITS-1:0] code, input phase_type ph);
      stim_row_type row;
      row = '0;
      row.gate = g;
      row.typed = typed;
      row.result.dac_code = code;
      row.result.phase = ph;
      stim_table.push_back(row);
   endfunction

   function automatic logic [23:0] pick_value(input logic [23:0] hi, input logic [23:0] lo,
                                              input logic [23:0] top);
      int k;
      k = $urandom_range(9, 0);
      if (k == 0) return 24'd0;
      if (k == 1) return top;
      return 24'($urandom_range(hi, lo));
   endfunction

   // Both the port and the model copy change together; only called while idle.
   task automatic write_register(input csr_index_type idx, input logic [23:0] data);
      csr_wen   <= 1'b1;
      csr_index <= idx;
      csr_wdata <= data;
      case (idx)
         CSR_EXP_MODE:      env_cfg.exp_mode      = data[0];
         CSR_SUSTAIN_LEVEL: env_cfg.sustain_level = data[SUSTAIN_BITS-1:0];
         CSR_ATTACK_RATE:   env_cfg.attack_rate   = data;
         CSR_DECAY_RATE:    env_cfg.decay_rate    = data;
         CSR_RELEASE_RATE:  env_cfg.release_rate  = data;
         CSR_ATTACK_COEF:   env_cfg.attack_coef   = data[COEF_BITS-1:0];
         CSR_DECAY_COEF:    env_cfg.decay_coef    = data[COEF_BITS-1:0];
         CSR_RELEASE_COEF:  env_cfg.release_coef  = data[COEF_BITS-1:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   task automatic wait_for_results();
      req_valid <= 1'b0;
      csr_wen   <= 1'b0;
      while (pending_outputs.size() != 0) @(posedge clock);
      repeat (4) @(posedge clock);
   endtask

   task automatic send_tick(input logic g, input bit typed, input tick_result_type typed_result);
      tick_result_type predicted;
      bit              calm;
      csr_wen <= 1'b0;
      calm = (ticks_sent >= 300 && ticks_sent < 550);
      if (!calm && $urandom_range(99, 0) < 13) begin
         req_valid <= 1'b0;
         @(posedge clock);
      end
      predicted = advance_envelope(g);
      pending_outputs.push_back(typed ? typed_result : predicted);
      req_valid <= 1'b1;
      req_gate  <= g;
      @(posedge clock);
      while (!req_ready) @(posedge clock);
      ticks_sent++;
   endtask

   // Result side: random stalls, a calm window, and one long hold-off on request.
   initial begin
      int cycle_count;
      cycle_count = 0;
      forever begin
         @(posedge clock);
         cycle_count++;
         if (hold_request) begin
            hold_request = 1'b0;
            rsp_ready <= 1'b0;
            repeat (HOLD_CYCLES - 1) @(posedge clock);
            cycle_count += HOLD_CYCLES - 1;
         end else begin
            rsp_ready <= (cycle_count >= 1500 && cycle_count < 2300) ||
                         ($urandom_range(99, 0) >= 13);
         end
      end
   end

   always @(posedge clock) begin
      tick_result_type want;
      if (!reset && rsp_valid && rsp_ready) begin
         if (pending_outputs.size() == 0) begin
            $display("%0t: unexpected transaction, code %0d phase %0d",
                     $time, rsp_dac_code, rsp_phase);
            mismatch_count++;
         end else begin
            want = pending_outputs.pop_front();
            if (rsp_dac_code !== want.dac_code) begin
               $display("%0t: dac_code expected %0d actual %0d",
                        $time, want.dac_code, rsp_dac_code);
               mismatch_count++;
            end
            if (rsp_phase !== want.phase) begin
               $display("%0t: phase expected %0d actual %0d", $time, want.phase, rsp_phase);
               mismatch_count++;
            end
         end
      end
   end

   initial begin
      stim_row_type row;
      adsr_cfg_type next_cfg;
      int           phase_idx;
      int           budget;
      int           run_len;
      int           k;

      // Linear extremes: one-tick segments and a sustain above full scale.
      add_tick(1'b0, 1'b1, 12'd0, PH_OFF);
      add_write(CSR_ATTACK_RATE, 24'hFFFFFF);
      add_write(CSR_DECAY_RATE, 24'hFFFFFF);
      add_write(CSR_SUSTAIN_LEVEL, 24'h7FFFFF);
      add_tick(1'b1, 1'b1, 12'd0, PH_ATTACK);
      add_tick(1'b1, 1'b1, 12'd4094, PH_ATTACK);
      add_tick(1'b1, 1'b1, 12'd4095, PH_DECAY);
      add_tick(1'b1, 1'b1, 12'd4095, PH_SUSTAIN);
      add_tick(1'b1, 1'b1, 12'd4095, PH_SUSTAIN);
      add_write(CSR_RELEASE_RATE, 24'hFFFFFF);
      add_tick(1'b0, 1'b1, 12'd4095, PH_RELEASE);
      add_tick(1'b0, 1'b1, 12'd0, PH_RELEASE);
      add_tick(1'b1, 1'b1, 12'd0, PH_OFF);
      // Gate released during attack, with the minimum release step.
      add_write(CSR_SUSTAIN_LEVEL, 24'd0);
      add_write(CSR_RELEASE_RATE, 24'd0);
      add_tick(1'b1, 1'b1, 12'd0, PH_ATTACK);
      add_tick(1'b1, 1'b1, 12'd4094, PH_ATTACK);
      add_tick(1'b0, 1'b1, 12'd4094, PH_RELEASE);
      add_tick(1'b0, 1'b1, 12'd4094, PH_RELEASE);
      // Exponential mode switched in mid-release; zero coefficients jump at once.
      add_write(CSR_EXP_MODE, 24'd1);
      add_write(CSR_RELEASE_COEF, 24'd0);
      add_tick(1'b0, 1'b1, 12'd0, PH_OFF);
      add_write(CSR_ATTACK_COEF, 24'd0);
      add_tick(1'b1, 1'b1, 12'd0, PH_ATTACK);
      add_tick(1'b1, 1'b1, 12'd4095, PH_DECAY);
      add_write(CSR_DECAY_COEF, 24'hFFFF);
      add_write(CSR_SUSTAIN_LEVEL, 24'h200000);
      add_tick(1'b1, 1'b0, 12'd0, PH_OFF);
      add_tick(1'b0, 1'b0, 12'd0, PH_OFF);
      add_tick(1'b1, 1'b1, 12'd0, PH_OFF);
      add_tick(1'b1, 1'b1, 12'd0, PH_ATTACK);
      add_tick(1'b1, 1'b1, 12'd4095, PH_DECAY);
      add_write(CSR_DECAY_COEF, 24'd0);
      add_tick(1'b1, 1'b1, 12'd2047, PH_SUSTAIN);
      // Sustain follows the register while the gate is held.
      add_write(CSR_SUSTAIN_LEVEL, 24'h400000);
      add_tick(1'b1, 1'b1, 12'd4095, PH_SUSTAIN);
      add_write(CSR_RELEASE_COEF, 24'hFFFF);
      add_tick(1'b0, 1'b1, 12'd4095, PH_RELEASE);
      add_tick(1'b0, 1'b0, 12'd0, PH_OFF);
      add_write(CSR_EXP_MODE, 24'd0);
      add_tick(1'b0, 1'b0, 12'd0, PH_OFF);
      add_write(CSR_EXP_MODE, 24'd1);
      add_write(CSR_RELEASE_COEF, 24'd0);
      add_write(CSR_ATTACK_COEF, 24'hFFFF);
      add_tick(1'b0, 1'b1, 12'd0, PH_OFF);

      repeat (12) @(posedge clock);
      reset <= 1'b0;

      foreach (stim_table[i]) begin
         row = stim_table[i];
         if (row.is_write) begin
            wait_for_results();
            write_register(row.index, row.data);
         end else begin
            send_tick(row.gate, row.typed, row.result);
         end
      end

      for (phase_idx = 0; phase_idx < 10; phase_idx++) begin
         wait_for_results();
         // A slow linear release would swallow the whole phase; cut it short.
         if (env_phase == PH_RELEASE) begin
            write_register(CSR_EXP_MODE, 24'd1);
            write_register(CSR_RELEASE_COEF, 24'd0);
            send_tick(1'b0, 1'b0, '0);
            wait_for_results();
         end
         case (phase_idx)
            0: begin
               next_cfg = '{1'b0, 23'h7FFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF,
                            16'hFFFF, 16'hFFFF, 16'hFFFF};
            end
            1: next_cfg = '{1'b1, 23'd0, 24'd0, 24'd0, 24'd0, 16'd0, 16'd0, 16'd0};
            default: begin
               next_cfg.exp_mode = 1'($urandom_range(1, 0));
               next_cfg.sustain_level = ($urandom_range(9, 0) == 0) ? 23'h7FFFFF :
                                        23'($urandom_range(32'h400000, 0));
               next_cfg.attack_rate  = pick_value(24'd4000000, 24'd200000, 24'hFFFFFF);
               next_cfg.decay_rate   = pick_value(24'd4000000, 24'd200000, 24'hFFFFFF);
               next_cfg.release_rate = pick_value(24'd4000000, 24'd200000, 24'hFFFFFF);
               next_cfg.attack_coef  = 16'(pick_value(24'd62000, 24'd30000, 24'hFFFF));
               next_cfg.decay_coef   = 16'(pick_value(24'd62000, 24'd30000, 24'hFFFF));
               next_cfg.release_coef = 16'(pick_value(24'd62000, 24'd30000, 24'hFFFF));
            end
         endcase
         write_register(CSR_EXP_MODE, {23'd0, next_cfg.exp_mode});
         write_register(CSR_SUSTAIN_LEVEL, {1'b0, next_cfg.sustain_level});
         write_register(CSR_ATTACK_RATE, next_cfg.attack_rate);
         write_register(CSR_DECAY_RATE, next_cfg.decay_rate);
         write_register(CSR_RELEASE_RATE, next_cfg.release_rate);
         write_register(CSR_ATTACK_COEF, {8'd0, next_cfg.attack_coef});
         write_register(CSR_DECAY_COEF, {8'd0, next_cfg.decay_coef});
         write_register(CSR_RELEASE_COEF, {8'd0, next_cfg.release_coef});

         // The sender keeps offering transactions through this stall.
         if (phase_idx == 3) hold_request = 1'b1;

         budget = 95;
         while (budget > 0) begin
            k = $urandom_range(99, 0);
            if (k < 5) begin
               wait_for_results();
            end else if (k < 15) begin
               run_len = $urandom_range(8, 1);
               repeat (run_len) send_tick(1'($urandom_range(1, 0)), 1'b0, '0);
               budget -= run_len;
            end else begin
               // A full note: gate held, then released for a random number of ticks.
               run_len = $urandom_range(50, 1);
               repeat (run_len) send_tick(1'b1, 1'b0, '0);
               budget -= run_len;
               run_len = $urandom_range(70, 1);
               repeat (run_len) send_tick(1'b0, 1'b0, '0);
               budget -= run_len;
            end
         end
      end

      wait_for_results();
      repeat (8) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

endmodule
